>>> src/median_position_nudge_checker_unit_assert.svh
// Assertion macros shared by the median position nudge checker RTL.
`ifndef MEDIAN_POSITION_NUDGE_CHECKER_UNIT_ASSERT_SVH
`define MEDIAN_POSITION_NUDGE_CHECKER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define MPNC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define MPNC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define MPNC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MPNC_ASSERT_ALWAYS(lbl, expr, msg)
`define MPNC_ASSERT_IMPLY(lbl, ante, cons, msg)
`define MPNC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> src/mpnc_pkg.sv
// Package: constants, types and state encodings of the median position nudge checker.
`default_nettype none
package mpnc_pkg;

  localparam int SAMPLES_PER_READING = 9;
  localparam int SAMPLE_BITS         = 10;

  localparam int CFG_W       = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int MEDIAN_W    = 10;
  localparam int SIGNED_W    = 11;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CFG_W-1:0] SANE_LOW_RESET  = 10'd20;
  localparam logic [CFG_W-1:0] SANE_HIGH_RESET = 10'd1000;
  localparam logic [CFG_W-1:0] MAX_STEP_RESET  = 10'd40;
  localparam logic [CFG_W-1:0] CENTER_RESET    = 10'd399;
  localparam logic [CFG_W-1:0] REACH_RESET     = 10'd2;
  localparam logic [CFG_W-1:0] PERMIT_RESET    = 10'd5;
  localparam logic [CFG_W-1:0] SLACK_RESET     = 10'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SANE_LOW      = 3'd0,
    CFG_SANE_HIGH     = 3'd1,
    CFG_MAX_STEP      = 3'd2,
    CFG_CENTER        = 3'd3,
    CFG_REACH         = 3'd4,
    CFG_PERMIT        = 3'd5,
    CFG_REVERSE_SLACK = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] sane_low;
    logic [CFG_W-1:0] sane_high;
    logic [CFG_W-1:0] max_step;
    logic [CFG_W-1:0] center;
    logic [CFG_W-1:0] reach;
    logic [CFG_W-1:0] permit;
    logic [CFG_W-1:0] slack;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_JUMP     = 3'd2,
    ST_OPPOSITE = 3'd3,
    ST_HALTED   = 3'd4
  } status_t;

  typedef struct packed {
    logic [MEDIAN_W-1:0] median;
    logic [SIGNED_W-1:0] center_offset;
    logic [SIGNED_W-1:0] movement;
    status_t             status;
    logic                midpoint_reached;
    logic                adjust_allowed;
  } result_t;

  typedef struct packed {
    logic commit;
    logic is_nudge;
    logic dir_left;
  } check_ctl_t;

  typedef enum logic [1:0] {
    T_COLLECT,
    T_SEARCH,
    T_CHECK
  } top_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CAND_RD,
    S_CAND_LD,
    S_SCAN,
    S_DECIDE
  } sel_state_t;

endpackage
`default_nettype wire

>>> src/mpnc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mpnc_ram #(
  parameter int WIDTH = mpnc_pkg::SAMPLE_BITS,
  parameter int DEPTH = mpnc_pkg::SAMPLES_PER_READING
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/mpnc_select.sv
// Median search: rank counting of each candidate with one shared comparator.
`default_nettype none
`include "median_position_nudge_checker_unit_assert.svh"
module mpnc_select #(
  parameter int SAMPLES_PER_READING = mpnc_pkg::SAMPLES_PER_READING,
  parameter int SAMPLE_BITS         = mpnc_pkg::SAMPLE_BITS
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  output logic [$clog2(SAMPLES_PER_READING)-1:0]   ram_raddr,
  input  logic [SAMPLE_BITS-1:0]                   ram_rdata,
  output logic                                     done,
  output logic [SAMPLE_BITS-1:0]                   median
);

  localparam int IDX_W = $clog2(SAMPLES_PER_READING);
  localparam int CNT_W = $clog2(SAMPLES_PER_READING + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_PER_READING - 1);
  localparam logic [CNT_W-1:0] MID_RANK = CNT_W'(SAMPLES_PER_READING / 2);

  mpnc_pkg::sel_state_t state_r, state_nxt;
  logic [IDX_W-1:0]       cand_r, cand_nxt;
  logic [IDX_W-1:0]       scan_r, scan_nxt;
  logic [CNT_W-1:0]       lt_r, lt_nxt;
  logic [CNT_W-1:0]       le_r, le_nxt;
  logic [SAMPLE_BITS-1:0] cand_val_r, cand_val_nxt;
  logic                   is_lt, is_le, hit;

  // shared comparator
  assign is_lt = ram_rdata < cand_val_r;
  assign is_le = ram_rdata <= cand_val_r;
  assign hit   = (lt_r <= MID_RANK) && (le_r > MID_RANK);

  always_comb begin
    state_nxt    = state_r;
    cand_nxt     = cand_r;
    scan_nxt     = scan_r;
    lt_nxt       = lt_r;
    le_nxt       = le_r;
    cand_val_nxt = cand_val_r;
    ram_raddr    = '0;
    done         = 1'b0;
    unique case (state_r)
      mpnc_pkg::S_IDLE: begin
        if (start) begin
          cand_nxt  = '0;
          state_nxt = mpnc_pkg::S_CAND_RD;
        end
      end
      mpnc_pkg::S_CAND_RD: begin
        ram_raddr = cand_r;
        state_nxt = mpnc_pkg::S_CAND_LD;
      end
      mpnc_pkg::S_CAND_LD: begin
        cand_val_nxt = ram_rdata;
        ram_raddr    = '0;
        scan_nxt     = '0;
        lt_nxt       = '0;
        le_nxt       = '0;
        state_nxt    = mpnc_pkg::S_SCAN;
      end
      mpnc_pkg::S_SCAN: begin
        ram_raddr = (scan_r == LAST_IDX) ? '0 : IDX_W'(scan_r + 1'b1);
        lt_nxt    = CNT_W'(lt_r + CNT_W'(is_lt));
        le_nxt    = CNT_W'(le_r + CNT_W'(is_le));
        if (scan_r == LAST_IDX) begin
          state_nxt = mpnc_pkg::S_DECIDE;
        end else begin
          scan_nxt = IDX_W'(scan_r + 1'b1);
        end
      end
      mpnc_pkg::S_DECIDE: begin
        if (hit || cand_r == LAST_IDX) begin
          done      = 1'b1;
          state_nxt = mpnc_pkg::S_IDLE;
        end else begin
          cand_nxt  = IDX_W'(cand_r + 1'b1);
          state_nxt = mpnc_pkg::S_CAND_RD;
        end
      end
      default: state_nxt = mpnc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpnc_pkg::S_IDLE;
      cand_r  <= '0;
      scan_r  <= '0;
      lt_r    <= '0;
      le_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cand_r  <= cand_nxt;
      scan_r  <= scan_nxt;
      lt_r    <= lt_nxt;
      le_r    <= le_nxt;
    end
    cand_val_r <= cand_val_nxt;
  end

  assign median = cand_val_r;

  `MPNC_ASSERT_ALWAYS(a_cand_bound, cand_r <= LAST_IDX, "candidate index past burst")
  `MPNC_ASSERT_IMPLY(a_done_hit, done, hit, "median search ended without rank match")

endmodule
`default_nettype wire

>>> src/mpnc_check.sv
// Plausibility checks, reference position and fault latch; builds the result fields.
`default_nettype none
`include "median_position_nudge_checker_unit_assert.svh"
module mpnc_check #(
  parameter int SAMPLE_BITS = mpnc_pkg::SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mpnc_pkg::cfg_t         cfg,
  input  logic [SAMPLE_BITS-1:0] median,
  input  mpnc_pkg::check_ctl_t   ctl,
  output mpnc_pkg::result_t      res
);

  localparam int WIDE = ((SAMPLE_BITS > mpnc_pkg::CFG_W) ? SAMPLE_BITS : mpnc_pkg::CFG_W) + 2;

  logic [SAMPLE_BITS-1:0] ref_r, ref_nxt;
  logic                   fault_r, fault_nxt;

  logic signed [WIDE-1:0] med_x, ref_x, cen_x;
  logic signed [WIDE-1:0] err, err_abs, delta, delta_abs, move, ref_err, ref_err_abs;
  logic signed [WIDE-1:0] move_out;
  mpnc_pkg::status_t      status;
  logic                   take_new;

  always_comb begin
    med_x       = WIDE'(median);
    ref_x       = WIDE'(ref_r);
    cen_x       = WIDE'(cfg.center);
    err         = med_x - cen_x;
    err_abs     = err[WIDE-1] ? -err : err;
    delta       = med_x - ref_x;
    delta_abs   = delta[WIDE-1] ? -delta : delta;
    move        = ctl.dir_left ? delta : -delta;
    ref_err     = ref_x - cen_x;
    ref_err_abs = ref_err[WIDE-1] ? -ref_err : ref_err;

    priority if (fault_r) begin
      status = mpnc_pkg::ST_HALTED;
    end else if (!ctl.is_nudge) begin
      status = mpnc_pkg::ST_OK;
    end else if (med_x < WIDE'(cfg.sane_low) || med_x > WIDE'(cfg.sane_high)) begin
      status = mpnc_pkg::ST_RANGE;
    end else if (delta_abs > WIDE'(cfg.max_step)) begin
      status = mpnc_pkg::ST_JUMP;
    end else if (move < -$signed(WIDE'(cfg.slack))) begin
      status = mpnc_pkg::ST_OPPOSITE;
    end else begin
      status = mpnc_pkg::ST_OK;
    end

    take_new = !fault_r && (status == mpnc_pkg::ST_OK);
    move_out = (!fault_r && ctl.is_nudge) ? move : '0;

    res.median           = mpnc_pkg::MEDIAN_W'(med_x);
    res.center_offset    = mpnc_pkg::SIGNED_W'(err);
    res.movement         = mpnc_pkg::SIGNED_W'(move_out);
    res.status           = status;
    res.midpoint_reached = take_new && ctl.is_nudge && (err_abs <= WIDE'(cfg.reach));
    res.adjust_allowed   = take_new ? (err_abs <= WIDE'(cfg.permit))
                                    : (ref_err_abs <= WIDE'(cfg.permit));

    ref_nxt   = ref_r;
    fault_nxt = fault_r;
    if (ctl.commit) begin
      if (take_new) begin
        ref_nxt = median;
      end else if (!fault_r) begin
        fault_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r   <= '0;
      fault_r <= 1'b0;
    end else begin
      ref_r   <= ref_nxt;
      fault_r <= fault_nxt;
    end
  end

  `MPNC_ASSERT_NEXT(a_fault_sticky, fault_r, fault_r, "fault latch cleared without reset")
  `MPNC_ASSERT_IMPLY(a_halt_quiet, fault_r,
                     res.movement == '0 && !res.midpoint_reached, "halted result not quiet")

endmodule
`default_nettype wire

>>> src/median_position_nudge_checker_unit.sv
// Top level of the median position nudge checker.
// Samples are taken one per cycle (in_tready high) into a small RAM until a burst of
// SAMPLES_PER_READING is complete; the transaction that completes the burst supplies the
// burst kind (in_tuser) and the commanded direction. The median is then found by rank
// counting with one shared comparator reading the RAM one entry per cycle: each candidate
// is read from the RAM and all SAMPLES_PER_READING entries are scanned against it, for at
// most SAMPLES_PER_READING candidates; then the check loads the output register, later
// while an earlier result still waits there; in_tready is low all that time. The result
// waits in the output register while the next burst is collected. Configuration writes
// are taken at any edge with cfg_we high; indexes beyond the register list are ignored.
// A latched fault is cleared only by reset.
`default_nettype none
`include "median_position_nudge_checker_unit_assert.svh"
module median_position_nudge_checker_unit #(
  parameter int SAMPLES_PER_READING = mpnc_pkg::SAMPLES_PER_READING,
  parameter int SAMPLE_BITS         = mpnc_pkg::SAMPLE_BITS
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // sample [SAMPLE_BITS-1:0], direction [SAMPLE_BITS], zero fill
  input  logic [((SAMPLE_BITS + 8) / 8) * 8 - 1:0] in_tdata,
  // req_type
  input  logic                                     in_tuser,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // median [9:0], center_offset [20:10], movement [31:21], status [34:32],
  // midpoint_reached [35], adjust_allowed [36], zero fill
  output logic [mpnc_pkg::OUT_TDATA_W-1:0]         out_tdata,
  input  logic                                     cfg_we,
  input  logic [mpnc_pkg::CFG_IDX_W-1:0]           cfg_addr,
  input  logic [mpnc_pkg::CFG_W-1:0]               cfg_wdata
);

  localparam int IDX_W = $clog2(SAMPLES_PER_READING);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_PER_READING - 1);

  mpnc_pkg::top_state_t state_r, state_nxt;
  logic [IDX_W-1:0]     cnt_r, cnt_nxt;
  logic                 nudge_r, nudge_nxt;
  logic                 dir_r, dir_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [mpnc_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  mpnc_pkg::cfg_t       cfg_r, cfg_nxt;

  logic                   accept, last, commit, sel_start, sel_done;
  logic [IDX_W-1:0]       ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata, sel_median;
  mpnc_pkg::check_ctl_t   chk_ctl;
  mpnc_pkg::result_t      res;

  assign in_tready = (state_r == mpnc_pkg::T_COLLECT);
  assign accept    = in_tvalid && in_tready;
  assign last      = (cnt_r == LAST_IDX);
  assign sel_start = accept && last;
  assign commit    = (state_r == mpnc_pkg::T_CHECK) && (!out_valid_r || out_tready);

  assign chk_ctl.commit   = commit;
  assign chk_ctl.is_nudge = nudge_r;
  assign chk_ctl.dir_left = dir_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        mpnc_pkg::CFG_SANE_LOW:      cfg_nxt.sane_low  = cfg_wdata;
        mpnc_pkg::CFG_SANE_HIGH:     cfg_nxt.sane_high = cfg_wdata;
        mpnc_pkg::CFG_MAX_STEP:      cfg_nxt.max_step  = cfg_wdata;
        mpnc_pkg::CFG_CENTER:        cfg_nxt.center    = cfg_wdata;
        mpnc_pkg::CFG_REACH:         cfg_nxt.reach     = cfg_wdata;
        mpnc_pkg::CFG_PERMIT:        cfg_nxt.permit    = cfg_wdata;
        mpnc_pkg::CFG_REVERSE_SLACK: cfg_nxt.slack     = cfg_wdata;
        default:                     cfg_nxt           = cfg_r;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    nudge_nxt     = nudge_r;
    dir_nxt       = dir_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      mpnc_pkg::T_COLLECT: begin
        if (accept) begin
          if (last) begin
            cnt_nxt   = '0;
            nudge_nxt = in_tuser;
            dir_nxt   = in_tdata[SAMPLE_BITS];
            state_nxt = mpnc_pkg::T_SEARCH;
          end else begin
            cnt_nxt = IDX_W'(cnt_r + 1'b1);
          end
        end
      end
      mpnc_pkg::T_SEARCH: begin
        if (sel_done) begin
          state_nxt = mpnc_pkg::T_CHECK;
        end
      end
      mpnc_pkg::T_CHECK: begin
        if (commit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'b000, res.adjust_allowed, res.midpoint_reached, res.status,
                           res.movement, res.center_offset, res.median};
          state_nxt     = mpnc_pkg::T_COLLECT;
        end
      end
      default: state_nxt = mpnc_pkg::T_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpnc_pkg::T_COLLECT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      cfg_r       <= '{sane_low:  mpnc_pkg::SANE_LOW_RESET,
                       sane_high: mpnc_pkg::SANE_HIGH_RESET,
                       max_step:  mpnc_pkg::MAX_STEP_RESET,
                       center:    mpnc_pkg::CENTER_RESET,
                       reach:     mpnc_pkg::REACH_RESET,
                       permit:    mpnc_pkg::PERMIT_RESET,
                       slack:     mpnc_pkg::SLACK_RESET};
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
    end
    nudge_r    <= nudge_nxt;
    dir_r      <= dir_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  mpnc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (SAMPLES_PER_READING)
  ) u_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (cnt_r),
    .wdata (in_tdata[SAMPLE_BITS-1:0]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mpnc_select #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING),
    .SAMPLE_BITS         (SAMPLE_BITS)
  ) u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (sel_start),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .done      (sel_done),
    .median    (sel_median)
  );

  mpnc_check #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .median (sel_median),
    .ctl    (chk_ctl),
    .res    (res)
  );

  `MPNC_ASSERT_IMPLY(a_done_in_search, sel_done, state_r == mpnc_pkg::T_SEARCH,
                     "median search finished outside search phase")
  `MPNC_ASSERT_NEXT(a_commit_shows, commit, out_tvalid, "committed result not presented")

endmodule
`default_nettype wire
